// ----- hw/rtl/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared widths, register codes and pipeline tag types of the corridor block
// test.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int CFG_W   = 31;   // configuration register width
    localparam int POS_W   = 32;   // Q16.16 coordinate width
    localparam int AXIS_W  = 16;   // Q2.14 axis and direction width
    localparam int DIFF_W  = 33;   // difference of two coordinates
    localparam int RAD_W   = 64;   // square root radicand
    localparam int ROOT_W  = 32;   // square root result
    localparam int DIST_W  = 33;   // 3D distance after the range fit doubling
    localparam int CPROD_W = 48;   // axis times extent
    localparam int CRN_W   = 49;   // corner offset, Q.30
    localparam int PROJ_W  = 65;   // corner times direction, Q.44
    localparam int SUM_W   = 66;   // side / forward projection, Q.44
    localparam int LIM_W   = 64;   // limit and half width, Q.44
    localparam int QUO_W   = 16;   // quotient bits of the direction divider
    localparam int DREM_W  = 48;   // divider remainder
    localparam int CORNERS = 4;

    localparam logic [QUO_W-1:0] UNIT_Q14 = 16'd16384;
    localparam logic [LIM_W-1:0] ONE_Q16  = 64'd131072;

    typedef enum logic [2:0] {
        REG_FRONT  = 3'd0,
        REG_BACK   = 3'd1,
        REG_LEFT   = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_VWIDTH = 3'd4,
        REG_LOOK   = 3'd5
    } cfg_reg_t;

    typedef logic signed [CRN_W-1:0] crn_t;

    // Carried alongside the square roots
    typedef struct packed {
        crn_t [CORNERS-1:0]  cx;
        crn_t [CORNERS-1:0]  cz;
        logic                sgn_x;
        logic                sgn_z;
        logic [ROOT_W-1:0]   mag_x;
        logic [ROOT_W-1:0]   mag_z;
        logic                dshift;
    } sq_tag_t;

    // Carried alongside the direction divider
    typedef struct packed {
        crn_t [CORNERS-1:0]  cx;
        crn_t [CORNERS-1:0]  cz;
        logic                sgn_x;
        logic                sgn_z;
        logic [DIST_W-1:0]   dist_q16;
        logic                zero;
    } dv_tag_t;

    // Halve toward zero when the range fit asks for it, keep 32 bits
    function automatic logic [POS_W-1:0] fit_half(input logic signed [DIFF_W-1:0] v,
                                                  input logic halve);
        logic signed [DIFF_W-1:0] t;
        begin
            t = v[DIFF_W-1] ? (v + 33'sd1) : v;
            fit_half = halve ? t[DIFF_W-1:1] : v[POS_W-1:0];
        end
    endfunction

    function automatic logic fits32(input logic signed [DIFF_W-1:0] v);
        fits32 = (v[DIFF_W-1] == v[DIFF_W-2]);
    endfunction

endpackage

// ----- hw/rtl/bcc_sqrt.sv -----
// ----------------------------------------------------------------------------
// bcc_sqrt
// Pipelined digit-by-digit square root of two radicands in lockstep, one
// result bit per stage.
// ----------------------------------------------------------------------------
module bcc_sqrt
    import bcc_pkg::*;
#(
    parameter int STEPS = 32,
    parameter int TAG_W = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [RAD_W-1:0]   in_rad_a,
    input  logic [RAD_W-1:0]   in_rad_b,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_valid,
    output logic [ROOT_W-1:0]  out_root_a,
    output logic [ROOT_W-1:0]  out_root_b,
    output logic [TAG_W-1:0]   out_tag
);

    localparam int NST = (STEPS < ROOT_W) ? STEPS : ROOT_W;

    logic [NST-1:0]    v_reg;
    logic [RAD_W-1:0]  rem_a_reg  [NST];
    logic [RAD_W-1:0]  rem_b_reg  [NST];
    logic [ROOT_W-1:0] root_a_reg [NST];
    logic [ROOT_W-1:0] root_b_reg [NST];
    logic [TAG_W-1:0]  tag_reg    [NST];

    for (genvar i = 0; i < NST; i++) begin : g_step
        localparam int B = ROOT_W - 1 - i;
        logic              v_in;
        logic [RAD_W-1:0]  rem_a_in, rem_b_in, rem_a_next, rem_b_next;
        logic [ROOT_W-1:0] root_a_in, root_b_in, root_a_next, root_b_next;
        logic [TAG_W-1:0]  tag_in;
        logic [RAD_W+1:0]  trial_a, trial_b;

        if (i == 0) begin : g_first
            assign v_in      = in_valid;
            assign rem_a_in  = in_rad_a;
            assign rem_b_in  = in_rad_b;
            assign root_a_in = '0;
            assign root_b_in = '0;
            assign tag_in    = in_tag;
        end
        else begin : g_next
            assign v_in      = v_reg[i-1];
            assign rem_a_in  = rem_a_reg[i-1];
            assign rem_b_in  = rem_b_reg[i-1];
            assign root_a_in = root_a_reg[i-1];
            assign root_b_in = root_b_reg[i-1];
            assign tag_in    = tag_reg[i-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 4^B
        assign trial_a = ({34'd0, root_a_in} << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
        assign trial_b = ({34'd0, root_b_in} << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));

        always_comb
        begin
            rem_a_next  = rem_a_in;
            root_a_next = root_a_in;
            rem_b_next  = rem_b_in;
            root_b_next = root_b_in;
            if (trial_a <= {2'b00, rem_a_in})
            begin
                rem_a_next     = rem_a_in - trial_a[RAD_W-1:0];
                root_a_next[B] = 1'b1;
            end
            if (trial_b <= {2'b00, rem_b_in})
            begin
                rem_b_next     = rem_b_in - trial_b[RAD_W-1:0];
                root_b_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_a_reg[i]  <= rem_a_next;
            rem_b_reg[i]  <= rem_b_next;
            root_a_reg[i] <= root_a_next;
            root_b_reg[i] <= root_b_next;
            tag_reg[i]    <= tag_in;
        end
    end

    assign out_valid  = v_reg[NST-1];
    assign out_root_a = root_a_reg[NST-1];
    assign out_root_b = root_b_reg[NST-1];
    assign out_tag    = tag_reg[NST-1];

endmodule

// ----- hw/rtl/bcc_div.sv -----
// ----------------------------------------------------------------------------
// bcc_div
// Pipelined restoring divider: two magnitudes scaled by 2^14 over one shared
// divisor, one quotient bit per stage, with an overflow flag per quotient.
// ----------------------------------------------------------------------------
module bcc_div
    import bcc_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [ROOT_W-1:0]  in_num_a,
    input  logic [ROOT_W-1:0]  in_num_b,
    input  logic [ROOT_W-1:0]  in_den,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_valid,
    output logic [QUO_W-1:0]   out_q_a,
    output logic [QUO_W-1:0]   out_q_b,
    output logic               out_ovf_a,
    output logic               out_ovf_b,
    output logic [TAG_W-1:0]   out_tag
);

    logic [QUO_W-1:0]  v_reg;
    logic [DREM_W-1:0] rem_a_reg [QUO_W];
    logic [DREM_W-1:0] rem_b_reg [QUO_W];
    logic [QUO_W-1:0]  q_a_reg   [QUO_W];
    logic [QUO_W-1:0]  q_b_reg   [QUO_W];
    logic [QUO_W-1:0]  ovf_a_reg;
    logic [QUO_W-1:0]  ovf_b_reg;
    logic [ROOT_W-1:0] den_reg   [QUO_W];
    logic [TAG_W-1:0]  tag_reg   [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_step
        localparam int B = QUO_W - 1 - i;
        logic              v_in, ovf_a_in, ovf_b_in;
        logic [DREM_W-1:0] rem_a_in, rem_b_in, rem_a_next, rem_b_next, dsh;
        logic [QUO_W-1:0]  q_a_in, q_b_in, q_a_next, q_b_next;
        logic [ROOT_W-1:0] den_in;
        logic [TAG_W-1:0]  tag_in;

        if (i == 0) begin : g_first
            assign v_in     = in_valid;
            assign rem_a_in = {2'b00, in_num_a, 14'd0};
            assign rem_b_in = {2'b00, in_num_b, 14'd0};
            assign q_a_in   = '0;
            assign q_b_in   = '0;
            assign ovf_a_in = ({2'b00, in_num_a} >= {in_den, 2'b00});
            assign ovf_b_in = ({2'b00, in_num_b} >= {in_den, 2'b00});
            assign den_in   = in_den;
            assign tag_in   = in_tag;
        end
        else begin : g_next
            assign v_in     = v_reg[i-1];
            assign rem_a_in = rem_a_reg[i-1];
            assign rem_b_in = rem_b_reg[i-1];
            assign q_a_in   = q_a_reg[i-1];
            assign q_b_in   = q_b_reg[i-1];
            assign ovf_a_in = ovf_a_reg[i-1];
            assign ovf_b_in = ovf_b_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign tag_in   = tag_reg[i-1];
        end

        assign dsh = {16'd0, den_in} << B;

        always_comb
        begin
            rem_a_next = rem_a_in;
            rem_b_next = rem_b_in;
            q_a_next   = q_a_in;
            q_b_next   = q_b_in;
            if (rem_a_in >= dsh)
            begin
                rem_a_next  = rem_a_in - dsh;
                q_a_next[B] = 1'b1;
            end
            if (rem_b_in >= dsh)
            begin
                rem_b_next  = rem_b_in - dsh;
                q_b_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_a_reg[i] <= rem_a_next;
            rem_b_reg[i] <= rem_b_next;
            q_a_reg[i]   <= q_a_next;
            q_b_reg[i]   <= q_b_next;
            ovf_a_reg[i] <= ovf_a_in;
            ovf_b_reg[i] <= ovf_b_in;
            den_reg[i]   <= den_in;
            tag_reg[i]   <= tag_in;
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_q_a   = q_a_reg[QUO_W-1];
    assign out_q_b   = q_b_reg[QUO_W-1];
    assign out_ovf_a = ovf_a_reg[QUO_W-1];
    assign out_ovf_b = ovf_b_reg[QUO_W-1];
    assign out_tag   = tag_reg[QUO_W-1];

endmodule

// ----- hw/rtl/box_corner_corridor_block_test.sv -----
// ----------------------------------------------------------------------------
// box_corner_corridor_block_test
// Flags a box obstacle whose corners fall inside the corridor from a vehicle
// toward its target.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the item fields with start high; the item is taken
//   at the rising edge where start is high and busy is low. busy stays low, so
//   a new item may be issued in every cycle.
//   Result channel: done pulses for one cycle with blocking; the receiver
//   cannot hold it off, and none is needed since the pipeline never stalls.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//   register, cfg_data[30:0] is stored. cfg_ready is always high. Write only
//   while no item is in flight.
//   Pipeline: accept to done runs through the square root pipeline (one root
//   bit per stage) and the 16-stage direction divider. Throughput: one item
//   per cycle.
//   Reset: clears all valid bits, so no done appears until items arrive, and
//   loads the register defaults (vehicle_width = 2.0, others zero).
// ----------------------------------------------------------------------------
module box_corner_corridor_block_test
    import bcc_pkg::*;
#(
    parameter int SQRT_STEPS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [POS_W-1:0]   pos_z,
    input  logic signed [POS_W-1:0]   target_x,
    input  logic signed [POS_W-1:0]   target_y,
    input  logic signed [POS_W-1:0]   target_z,
    input  logic signed [POS_W-1:0]   obstacle_x,
    input  logic signed [POS_W-1:0]   obstacle_z,
    input  logic signed [AXIS_W-1:0]  fwd_axis_x,
    input  logic signed [AXIS_W-1:0]  fwd_axis_z,
    input  logic signed [AXIS_W-1:0]  side_axis_x,
    input  logic signed [AXIS_W-1:0]  side_axis_z,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [31:0]               cfg_data,
    output logic                      done,
    output logic                      blocking
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] front_extent_reg, back_extent_reg, left_extent_reg;
    logic [CFG_W-1:0] right_extent_reg, vehicle_width_reg, look_ahead_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_extent_reg  <= '0;
            back_extent_reg   <= '0;
            left_extent_reg   <= '0;
            right_extent_reg  <= '0;
            vehicle_width_reg <= 31'd131072;
            look_ahead_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRONT:  front_extent_reg  <= cfg_data[CFG_W-1:0];
                REG_BACK:   back_extent_reg   <= cfg_data[CFG_W-1:0];
                REG_LEFT:   left_extent_reg   <= cfg_data[CFG_W-1:0];
                REG_RIGHT:  right_extent_reg  <= cfg_data[CFG_W-1:0];
                REG_VWIDTH: vehicle_width_reg <= cfg_data[CFG_W-1:0];
                REG_LOOK:   look_ahead_reg    <= cfg_data[CFG_W-1:0];
                default:    ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: take the item, form the differences
    // ------------------------------------------------------------------
    logic                       v1_reg;
    logic signed [DIFF_W-1:0]   hx_reg, hy_reg, hz_reg, dox_reg, doz_reg;
    logic signed [AXIS_W-1:0]   fx_reg, fz_reg, sx_reg, sz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        hx_reg  <= DIFF_W'(target_x) - DIFF_W'(pos_x);
        hy_reg  <= DIFF_W'(target_y) - DIFF_W'(pos_y);
        hz_reg  <= DIFF_W'(target_z) - DIFF_W'(pos_z);
        dox_reg <= DIFF_W'(obstacle_x) - DIFF_W'(pos_x);
        doz_reg <= DIFF_W'(obstacle_z) - DIFF_W'(pos_z);
        fx_reg  <= fwd_axis_x;
        fz_reg  <= fwd_axis_z;
        sx_reg  <= side_axis_x;
        sz_reg  <= side_axis_z;
    end

    // ------------------------------------------------------------------
    // Stage 2: range fit, squares and axis-times-extent products
    // ------------------------------------------------------------------
    logic                       halve2, halve3;
    logic signed [POS_W-1:0]    ax2, az2, ax3, ay3, az3;
    logic signed [POS_W:0]      fe_f, fe_b, se_l, se_r;

    assign halve2 = !fits32(hx_reg) || !fits32(hz_reg);
    assign halve3 = halve2 || !fits32(hy_reg);
    assign ax2    = fit_half(hx_reg, halve2);
    assign az2    = fit_half(hz_reg, halve2);
    assign ax3    = fit_half(hx_reg, halve3);
    assign ay3    = fit_half(hy_reg, halve3);
    assign az3    = fit_half(hz_reg, halve3);
    assign fe_f   = {2'b00, front_extent_reg};
    assign fe_b   = {2'b00, back_extent_reg};
    assign se_l   = {2'b00, left_extent_reg};
    assign se_r   = {2'b00, right_extent_reg};

    logic                        v2_reg;
    logic [RAD_W-1:0]            sq2x_reg, sq2z_reg, sq3x_reg, sq3y_reg, sq3z_reg;
    logic                        sgn_x2_reg, sgn_z2_reg, dshift2_reg;
    logic [ROOT_W-1:0]           mag_x2_reg, mag_z2_reg;
    logic signed [DIFF_W-1:0]    dox2_reg, doz2_reg;
    logic signed [CPROD_W-1:0]   pfxf_reg, pfxb_reg, psxl_reg, psxr_reg;
    logic signed [CPROD_W-1:0]   pfzf_reg, pfzb_reg, pszl_reg, pszr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    // widen before multiplying so the full products are kept
    always_ff @(posedge clk)
    begin
        sq2x_reg    <= RAD_W'(RAD_W'(ax2) * RAD_W'(ax2));
        sq2z_reg    <= RAD_W'(RAD_W'(az2) * RAD_W'(az2));
        sq3x_reg    <= RAD_W'(RAD_W'(ax3) * RAD_W'(ax3));
        sq3y_reg    <= RAD_W'(RAD_W'(ay3) * RAD_W'(ay3));
        sq3z_reg    <= RAD_W'(RAD_W'(az3) * RAD_W'(az3));
        sgn_x2_reg  <= ax2[POS_W-1];
        sgn_z2_reg  <= az2[POS_W-1];
        mag_x2_reg  <= ax2[POS_W-1] ? ROOT_W'(-ax2) : ROOT_W'(ax2);
        mag_z2_reg  <= az2[POS_W-1] ? ROOT_W'(-az2) : ROOT_W'(az2);
        dshift2_reg <= halve3;
        dox2_reg    <= dox_reg;
        doz2_reg    <= doz_reg;
        pfxf_reg    <= CPROD_W'(fx_reg) * CPROD_W'(fe_f);
        pfxb_reg    <= CPROD_W'(fx_reg) * CPROD_W'(fe_b);
        psxl_reg    <= CPROD_W'(sx_reg) * CPROD_W'(se_l);
        psxr_reg    <= CPROD_W'(sx_reg) * CPROD_W'(se_r);
        pfzf_reg    <= CPROD_W'(fz_reg) * CPROD_W'(fe_f);
        pfzb_reg    <= CPROD_W'(fz_reg) * CPROD_W'(fe_b);
        pszl_reg    <= CPROD_W'(sz_reg) * CPROD_W'(se_l);
        pszr_reg    <= CPROD_W'(sz_reg) * CPROD_W'(se_r);
    end

    // ------------------------------------------------------------------
    // Stage 3: radicands and corner offsets (Q.30)
    // Corners 0,1 lie at the front, 2,3 at the back; odd corners at the right.
    // ------------------------------------------------------------------
    crn_t    ox_q30, oz_q30;
    sq_tag_t sq_tag_next;

    assign ox_q30 = CRN_W'(dox2_reg) <<< 14;
    assign oz_q30 = CRN_W'(doz2_reg) <<< 14;

    always_comb
    begin
        sq_tag_next.cx[0]  = ox_q30 - CRN_W'(pfxf_reg) - CRN_W'(psxl_reg);
        sq_tag_next.cx[1]  = ox_q30 - CRN_W'(pfxf_reg) + CRN_W'(psxr_reg);
        sq_tag_next.cx[2]  = ox_q30 + CRN_W'(pfxb_reg) - CRN_W'(psxl_reg);
        sq_tag_next.cx[3]  = ox_q30 + CRN_W'(pfxb_reg) + CRN_W'(psxr_reg);
        sq_tag_next.cz[0]  = oz_q30 - CRN_W'(pfzf_reg) - CRN_W'(pszl_reg);
        sq_tag_next.cz[1]  = oz_q30 - CRN_W'(pfzf_reg) + CRN_W'(pszr_reg);
        sq_tag_next.cz[2]  = oz_q30 + CRN_W'(pfzb_reg) - CRN_W'(pszl_reg);
        sq_tag_next.cz[3]  = oz_q30 + CRN_W'(pfzb_reg) + CRN_W'(pszr_reg);
        sq_tag_next.sgn_x  = sgn_x2_reg;
        sq_tag_next.sgn_z  = sgn_z2_reg;
        sq_tag_next.mag_x  = mag_x2_reg;
        sq_tag_next.mag_z  = mag_z2_reg;
        sq_tag_next.dshift = dshift2_reg;
    end

    logic             v3_reg;
    logic [RAD_W-1:0] r2_reg, r3_reg;
    sq_tag_t          sq_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        r2_reg     <= sq2x_reg + sq2z_reg;
        r3_reg     <= sq3x_reg + sq3y_reg + sq3z_reg;
        sq_tag_reg <= sq_tag_next;
    end

    // ------------------------------------------------------------------
    // Square roots: horizontal length and 3D target distance
    // ------------------------------------------------------------------
    logic              sq_valid;
    logic [ROOT_W-1:0] len, root3;
    sq_tag_t           sq_tag_out;

    bcc_sqrt #(
        .STEPS (SQRT_STEPS),
        .TAG_W ($bits(sq_tag_t))
    ) u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v3_reg),
        .in_rad_a   (r2_reg),
        .in_rad_b   (r3_reg),
        .in_tag     (sq_tag_reg),
        .out_valid  (sq_valid),
        .out_root_a (len),
        .out_root_b (root3),
        .out_tag    (sq_tag_out)
    );

    // ------------------------------------------------------------------
    // Divider: unit direction magnitudes |a| * 2^14 / len
    // ------------------------------------------------------------------
    dv_tag_t dv_tag_in, dv_tag_out;

    always_comb
    begin
        dv_tag_in.cx       = sq_tag_out.cx;
        dv_tag_in.cz       = sq_tag_out.cz;
        dv_tag_in.sgn_x    = sq_tag_out.sgn_x;
        dv_tag_in.sgn_z    = sq_tag_out.sgn_z;
        dv_tag_in.dist_q16 = sq_tag_out.dshift ? {root3, 1'b0} : {1'b0, root3};
        dv_tag_in.zero     = (len == '0);
    end

    logic             dv_valid, ovf_x, ovf_z;
    logic [QUO_W-1:0] q_x, q_z;

    bcc_div #(
        .TAG_W ($bits(dv_tag_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_num_a  (sq_tag_out.mag_x),
        .in_num_b  (sq_tag_out.mag_z),
        .in_den    (len),
        .in_tag    (dv_tag_in),
        .out_valid (dv_valid),
        .out_q_a   (q_x),
        .out_q_b   (q_z),
        .out_ovf_a (ovf_x),
        .out_ovf_b (ovf_z),
        .out_tag   (dv_tag_out)
    );

    // ------------------------------------------------------------------
    // Stage 5: clamp and sign the direction, scale the distance limit
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] umag_x, umag_z;

    assign umag_x = (ovf_x || (q_x > UNIT_Q14)) ? UNIT_Q14 : q_x;
    assign umag_z = (ovf_z || (q_z > UNIT_Q14)) ? UNIT_Q14 : q_z;

    logic                       v5_reg, zero5_reg;
    logic signed [AXIS_W-1:0]   ux_reg, uz_reg;
    logic signed [LIM_W-1:0]    limit5_reg;
    crn_t [CORNERS-1:0]         cx5_reg, cz5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        ux_reg     <= dv_tag_out.sgn_x ? -umag_x : umag_x;
        uz_reg     <= dv_tag_out.sgn_z ? -umag_z : umag_z;
        limit5_reg <= (LIM_W'(dv_tag_out.dist_q16) + LIM_W'(look_ahead_reg)) << 28;
        zero5_reg  <= dv_tag_out.zero;
        cx5_reg    <= dv_tag_out.cx;
        cz5_reg    <= dv_tag_out.cz;
    end

    // ------------------------------------------------------------------
    // Stage 6: corner times direction products (Q.44)
    // ------------------------------------------------------------------
    logic                              v6_reg, zero6_reg;
    logic signed [LIM_W-1:0]           limit6_reg;
    logic signed [PROJ_W-1:0]          pzux_reg [CORNERS];
    logic signed [PROJ_W-1:0]          pxuz_reg [CORNERS];
    logic signed [PROJ_W-1:0]          pxux_reg [CORNERS];
    logic signed [PROJ_W-1:0]          pzuz_reg [CORNERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        zero6_reg  <= zero5_reg;
        limit6_reg <= limit5_reg;
        for (int k = 0; k < CORNERS; k++)
        begin
            pzux_reg[k] <= PROJ_W'(cz5_reg[k]) * PROJ_W'(ux_reg);
            pxuz_reg[k] <= PROJ_W'(cx5_reg[k]) * PROJ_W'(uz_reg);
            pxux_reg[k] <= PROJ_W'(cx5_reg[k]) * PROJ_W'(ux_reg);
            pzuz_reg[k] <= PROJ_W'(cz5_reg[k]) * PROJ_W'(uz_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: side and forward projections
    // ------------------------------------------------------------------
    logic                       v7_reg, zero7_reg;
    logic signed [LIM_W-1:0]    limit7_reg;
    logic signed [SUM_W-1:0]    side_reg [CORNERS];
    logic signed [SUM_W-1:0]    fwd_reg  [CORNERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        zero7_reg  <= zero6_reg;
        limit7_reg <= limit6_reg;
        for (int k = 0; k < CORNERS; k++)
        begin
            side_reg[k] <= SUM_W'(pzux_reg[k]) - SUM_W'(pxuz_reg[k]);
            fwd_reg[k]  <= SUM_W'(pxux_reg[k]) + SUM_W'(pzuz_reg[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: corridor tests and the result register
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] half_w, limit_w;
    logic                    hit;

    // corridor half width: (vehicle_width/2 + 1.0) in Q.44
    assign half_w  = SUM_W'((LIM_W'(vehicle_width_reg) + ONE_Q16) << 27);
    assign limit_w = SUM_W'(limit7_reg);

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < CORNERS; k++)
        begin
            if ((side_reg[k] > -half_w) && (side_reg[k] < half_w) &&
                (fwd_reg[k] > 0) && (fwd_reg[k] < limit_w))
                hit = 1'b1;
        end
    end

    logic done_reg, blocking_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            blocking_reg <= 1'b0;
        end
        else
        begin
            done_reg     <= v7_reg;
            blocking_reg <= v7_reg && !zero7_reg && hit;
        end
    end

    assign done     = done_reg;
    assign blocking = blocking_reg;

endmodule

// ----- hw/rtl/bcc_checker.sv -----
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks of the corridor block test, bound to the top level.
// ----------------------------------------------------------------------------
module bcc_checker
    import bcc_pkg::*;
#(
    parameter int SQRT_STEPS = 32
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cfg_valid,
    input logic cfg_ready,
    input logic done,
    input logic blocking
);

    localparam int LAT = 22 + ((SQRT_STEPS < ROOT_W) ? SQRT_STEPS : ROOT_W);

    // every result traces back to an item that the block accepted earlier
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT + 1))
        else $error("result without a matching item");

    a_blocking_marked: assert property (@(posedge clk)
        blocking |-> done)
        else $error("blocking shown outside a result cycle");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (!done && !blocking))
        else $error("result shown during reset");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && cfg_ready))
        else $error("block refused an item or a write");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write left waiting");

endmodule

bind box_corner_corridor_block_test bcc_checker #(.SQRT_STEPS(SQRT_STEPS)) u_bcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .done      (done),
    .blocking  (blocking)
);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the box corner corridor block test.
// Drives directed and random vehicle/target/obstacle items through the command
// port, predicts the blocking flag with an exact wide-integer model and checks
// every done pulse against the oldest pending prediction, across several
// register settings.
// ----------------------------------------------------------------------------
module tb;
    import bcc_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
        logic signed [POS_W-1:0]  target_x, target_y, target_z;
        logic signed [POS_W-1:0]  obstacle_x, obstacle_z;
        logic signed [AXIS_W-1:0] fwd_axis_x, fwd_axis_z, side_axis_x, side_axis_z;
    } query_t;

    // Holds its own copy of the registers and the pending blocking flags.
    class corridor_board;
        wide_t front, back, left, right, vwidth, look;
        bit    pending_flags[$];
        int    mismatches;
        int    checked;
        int    flagged;

        function void reset_regs();
            front = 0; back = 0; left = 0; right = 0; vwidth = 131072; look = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            wide_t v;
            v = {97'd0, data[CFG_W-1:0]};
            case (idx)
                REG_FRONT:  front  = v;
                REG_BACK:   back   = v;
                REG_LEFT:   left   = v;
                REG_RIGHT:  right  = v;
                REG_VWIDTH: vwidth = v;
                REG_LOOK:   look   = v;
                default:    ;
            endcase
        endfunction

        // Floor square root, one result bit per step from bit 31 down.
        function wide_t root_floor(wide_t r);
            wide_t rt, t;
            rt = 0;
            for (int b = 31; b >= 0; b--)
            begin
                t = rt | (wide_t'(1) << b);
                if (t * t <= r)
                    rt = t;
            end
            return rt;
        endfunction

        function bit in_range32(wide_t v);
            return v >= -wide_t'(64'sd2147483648) && v <= wide_t'(64'sd2147483647);
        endfunction

        function bit corridor_hit(query_t q);
            wide_t hx, hy, hz, ax, ay, az, len, ux, uz, tdist, lim, half;
            wide_t fe, se, cx, cz, sd, fw;
            int    sh;
            hx = wide_t'(q.target_x) - wide_t'(q.pos_x);
            hy = wide_t'(q.target_y) - wide_t'(q.pos_y);
            hz = wide_t'(q.target_z) - wide_t'(q.pos_z);
            // target straight above or below: no horizontal direction
            if (hx == 0 && hz == 0)
                return 0;
            ax = hx; az = hz;
            if (!in_range32(ax) || !in_range32(az))
            begin
                ax = ax / 2; az = az / 2;
            end
            len = root_floor(ax * ax + az * az);
            if (len == 0)
                return 0;
            ux = (ax * 16384) / len;
            uz = (az * 16384) / len;
            if (ux > 16384) ux = 16384;
            if (ux < -16384) ux = -16384;
            if (uz > 16384) uz = 16384;
            if (uz < -16384) uz = -16384;
            ax = hx; ay = hy; az = hz; sh = 0;
            if (!in_range32(ax) || !in_range32(ay) || !in_range32(az))
            begin
                ax = ax / 2; ay = ay / 2; az = az / 2; sh = 1;
            end
            tdist = root_floor(ax * ax + ay * ay + az * az) << sh;
            lim   = (tdist + look) * 268435456;
            half  = (vwidth + 131072) * 134217728;
            for (int k = 0; k < CORNERS; k++)
            begin
                fe = (k < 2) ? -front : back;
                se = (k & 1) ? right : -left;
                cx = (wide_t'(q.obstacle_x) - wide_t'(q.pos_x)) * 16384
                     + wide_t'(q.fwd_axis_x) * fe + wide_t'(q.side_axis_x) * se;
                cz = (wide_t'(q.obstacle_z) - wide_t'(q.pos_z)) * 16384
                     + wide_t'(q.fwd_axis_z) * fe + wide_t'(q.side_axis_z) * se;
                sd = cz * ux - cx * uz;
                fw = cx * ux + cz * uz;
                if (sd > -half && sd < half && fw > 0 && fw < lim)
                    return 1;
            end
            return 0;
        endfunction

        function void note_item(query_t q);
            pending_flags.push_back(corridor_hit(q));
        endfunction

        function void check_result(logic got);
            bit want;
            if (pending_flags.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: blocking=%0b with nothing pending", got);
                return;
            end
            want = pending_flags.pop_front();
            checked++;
            if (want)
                flagged++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("blocking mismatch on result %0d: expected %0b, got %0b",
                             checked, want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [POS_W-1:0]  pos_x, pos_y, pos_z, target_x, target_y, target_z;
    logic signed [POS_W-1:0]  obstacle_x, obstacle_z;
    logic signed [AXIS_W-1:0] fwd_axis_x, fwd_axis_z, side_axis_x, side_axis_z;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic        blocking;

    corridor_board board;
    int            idle_cycles;
    int            items_sent;

    box_corner_corridor_block_test dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .obstacle_x(obstacle_x), .obstacle_z(obstacle_z),
        .fwd_axis_x(fwd_axis_x), .fwd_axis_z(fwd_axis_z),
        .side_axis_x(side_axis_x), .side_axis_z(side_axis_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .blocking(blocking)
    );

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    // Sample both handshakes at the edge; the drivers only change inputs via NBAs,
    // so the values seen here are the ones the block takes.
    always @(posedge clk)
    begin
        query_t q;
        logic   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (start && !busy)
            begin
                q.pos_x = pos_x; q.pos_y = pos_y; q.pos_z = pos_z;
                q.target_x = target_x; q.target_y = target_y; q.target_z = target_z;
                q.obstacle_x = obstacle_x; q.obstacle_z = obstacle_z;
                q.fwd_axis_x = fwd_axis_x; q.fwd_axis_z = fwd_axis_z;
                q.side_axis_x = side_axis_x; q.side_axis_z = side_axis_z;
                board.note_item(q);
                moved = 1'b1;
            end
            if (done)
            begin
                board.check_result(blocking);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                board.write_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: a stalled pipeline shows up as a long run of quiet cycles.
    always @(posedge clk)
    begin
        if (idle_cycles >= 5000)
        begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Write one register, holding valid until the channel takes it, then drop valid and idle.
    task automatic write_cfg(cfg_reg_t idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Issue one item and hold it until accepted; start stays high for a follower.
    task automatic issue(query_t q);
        pos_x <= q.pos_x; pos_y <= q.pos_y; pos_z <= q.pos_z;
        target_x <= q.target_x; target_y <= q.target_y; target_z <= q.target_z;
        obstacle_x <= q.obstacle_x; obstacle_z <= q.obstacle_z;
        fwd_axis_x <= q.fwd_axis_x; fwd_axis_z <= q.fwd_axis_z;
        side_axis_x <= q.side_axis_x; side_axis_z <= q.side_axis_z;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drain the pipeline, then allow the full latency before touching registers.
    task automatic drain();
        pause(1);
        while (board.pending_flags.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic signed [31:0] near_coord();
        return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    endfunction

    function automatic logic signed [15:0] unit_comp();
        return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endfunction

    // Mostly obstacles placed along the path toward the target with random pose,
    // the rest full-range noise that covers every bit of every field.
    function automatic query_t random_query();
        query_t q;
        longint hx, hz, t;
        if ($urandom_range(0, 9) < 2)
        begin
            q.pos_x = $urandom; q.pos_y = $urandom; q.pos_z = $urandom;
            q.target_x = $urandom; q.target_y = $urandom; q.target_z = $urandom;
            q.obstacle_x = $urandom; q.obstacle_z = $urandom;
            q.fwd_axis_x = $urandom; q.fwd_axis_z = $urandom;
            q.side_axis_x = $urandom; q.side_axis_z = $urandom;
            return q;
        end
        q.pos_x = near_coord(); q.pos_y = near_coord(); q.pos_z = near_coord();
        q.target_x = near_coord(); q.target_y = near_coord(); q.target_z = near_coord();
        if ($urandom_range(0, 19) == 0)
        begin
            q.target_x = q.pos_x;
            q.target_z = q.pos_z;
        end
        hx = longint'(q.target_x) - longint'(q.pos_x);
        hz = longint'(q.target_z) - longint'(q.pos_z);
        t = $urandom_range(0, 130);
        q.obstacle_x = 32'(longint'(q.pos_x) + hx * t / 100
                           + longint'($urandom_range(0, 800000)) - 400000);
        q.obstacle_z = 32'(longint'(q.pos_z) + hz * t / 100
                           + longint'($urandom_range(0, 800000)) - 400000);
        q.fwd_axis_x = unit_comp();
        q.fwd_axis_z = unit_comp();
        if ($urandom_range(0, 3) != 0)
        begin
            q.side_axis_x = -q.fwd_axis_z;
            q.side_axis_z = q.fwd_axis_x;
        end
        else
        begin
            q.side_axis_x = unit_comp();
            q.side_axis_z = unit_comp();
        end
        return q;
    endfunction

    // Random bursts with random gaps, plus stretches at full rate.
    task automatic random_phase(int count);
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && count > 0; i++, count--)
                issue(random_query());
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
    endtask

    task automatic set_all(logic [31:0] f, logic [31:0] b, logic [31:0] l,
                           logic [31:0] r, logic [31:0] w, logic [31:0] la);
        write_cfg(REG_FRONT, f);
        write_cfg(REG_BACK, b);
        write_cfg(REG_LEFT, l);
        write_cfg(REG_RIGHT, r);
        write_cfg(REG_VWIDTH, w);
        write_cfg(REG_LOOK, la);
    endtask

    task automatic directed();
        query_t q;
        // obstacle dead ahead, small box
        q.pos_x = 0; q.pos_y = 0; q.pos_z = 0;
        q.target_x = 32'sd655360; q.target_y = 0; q.target_z = 0;
        q.obstacle_x = 32'sd327680; q.obstacle_z = 0;
        q.fwd_axis_x = 16'sd16384; q.fwd_axis_z = 0;
        q.side_axis_x = 0; q.side_axis_z = 16'sd16384;
        issue(q);
        // obstacle behind the vehicle
        q.obstacle_x = -32'sd327680;
        issue(q);
        // obstacle beyond target distance
        q.obstacle_x = 32'sd983040;
        issue(q);
        // obstacle off to the side
        q.obstacle_x = 32'sd327680; q.obstacle_z = 32'sd655360;
        issue(q);
        // target straight above the vehicle
        q.target_x = 0; q.target_y = 32'sd655360; q.target_z = 0; q.obstacle_z = 0;
        issue(q);
        // extreme coordinates force the range fit on every difference
        q.pos_x = 32'sh8000_0000; q.pos_y = 32'sh8000_0000; q.pos_z = 32'sh8000_0000;
        q.target_x = 32'sh7FFF_FFFF; q.target_y = 32'sh7FFF_FFFF;
        q.target_z = 32'sh7FFF_FFFF;
        q.obstacle_x = 32'sh7FFF_FFFF; q.obstacle_z = 32'sh7FFF_FFFF;
        issue(q);
        q.obstacle_x = 0; q.obstacle_z = 0;
        issue(q);
        // reverse direction, extreme axes outside the unit range
        q.pos_x = 32'sh7FFF_FFFF; q.pos_z = 32'sh7FFF_FFFF; q.pos_y = 32'sh7FFF_FFFF;
        q.target_x = 32'sh8000_0000; q.target_z = 32'sh8000_0000;
        q.target_y = 32'sh8000_0000;
        q.fwd_axis_x = 16'sh8000; q.fwd_axis_z = 16'sh7FFF;
        q.side_axis_x = 16'sh7FFF; q.side_axis_z = 16'sh8000;
        issue(q);
        // one axis only overflows
        q.pos_x = 32'sh8000_0000; q.pos_z = 0; q.pos_y = 0;
        q.target_x = 32'sh0000_0001; q.target_z = 0; q.target_y = 0;
        q.obstacle_x = 32'sh8000_0000; q.obstacle_z = 0;
        q.fwd_axis_x = -16'sd16384; q.fwd_axis_z = 16'sd16384;
        q.side_axis_x = 16'sd16384; q.side_axis_z = -16'sd16384;
        issue(q);
        // smallest horizontal step
        q.pos_x = 0; q.target_x = 0; q.target_z = 1; q.obstacle_x = 0; q.obstacle_z = 1;
        issue(q);
        q.target_z = -1; q.obstacle_z = -1;
        issue(q);
        pause(1);
    endtask

    initial
    begin
        board = new();
        board.reset_regs();
        idle_cycles = 0;
        items_sent  = 0;
        start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        pos_x = '0; pos_y = '0; pos_z = '0;
        target_x = '0; target_y = '0; target_z = '0;
        obstacle_x = '0; obstacle_z = '0;
        fwd_axis_x = '0; fwd_axis_z = '0; side_axis_x = '0; side_axis_z = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults first: point-sized obstacle
        directed();
        random_phase(200);
        drain();

        // moderate box, a few units on each side
        set_all(32'h0002_0000, 32'h0003_0000, 32'h0001_8000, 32'h0002_8000,
                32'h0001_0000, 32'h0005_0000);
        // indexes past the last register must be ignored
        write_cfg(cfg_reg_t'(3'd6), 32'hFFFF_FFFF);
        write_cfg(cfg_reg_t'(3'd7), 32'h1234_5678);
        directed();
        random_phase(900);
        drain();

        // everything at its maximum, bit 31 of the data must be dropped
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed();
        random_phase(300);
        drain();

        // all zero: corridor half width is exactly one unit
        set_all(0, 0, 0, 0, 0, 0);
        random_phase(200);
        drain();

        // random registers in a useful range
        set_all($urandom_range(0, 32'h000A_0000), $urandom_range(0, 32'h000A_0000),
                $urandom_range(0, 32'h0005_0000), $urandom_range(0, 32'h0005_0000),
                $urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0100_0000));
        random_phase(500);
        drain();

        $display("ran %0d items over five register settings, %0d results checked",
                 items_sent, board.checked);
        $display("%0d results flagged blocking, %0d mismatches", board.flagged,
                 board.mismatches);
        if (board.mismatches == 0 && board.pending_flags.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
